[rtl/periodic_task_timer_table_macros.svh]
// assertion macros for the periodic task timer table
// used by the top level only, no other dependencies
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptt_pkg.sv]
// shared types and constants of the periodic task timer table
// no dependencies
package ptt_pkg;

    typedef enum logic [1:0] {
        OP_SCHED  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_RUN    = 2'd3
    } t_op;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_FIRED  = 2'd1;
    localparam logic [1:0] RK_DONE   = 2'd2;

    localparam int         MAX_RESULTS = 16;
    localparam logic [3:0] FIRE_SAT    = 4'(MAX_RESULTS - 1);

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  tag;
        logic [31:0] due;
        logic [31:0] period;
    } t_entry;

    // tm holds the due time for schedule/change and the current time for run
    typedef struct packed {
        t_op         op;
        logic [31:0] id;
        logic [7:0]  tag;
        logic [31:0] tm;
        logic [31:0] period;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCHED,
        BK_SWEEP,
        BK_FINISH
    } t_bk_state;

endpackage

[rtl/periodic_task_timer_table.sv]
// top level of the periodic task timer table: front end, command queue and back end
// depends on ptt_pkg, ptt_front, ptt_back and periodic_task_timer_table_macros.svh
//
// channel   direction  transfer                     payload
// request   in         start high and busy low      i_req_type .. i_now_time
// result    out        o_res_valid high, one cycle  o_result_kind .. o_last
//
// a schedule is written to the table in the back end's schedule state unless it is full,
// and its status result is registered; remove, change and run sweep the n entries held
// and then give their last result: the sweep reads the table through its single read
// port, one entry per cycle, re-appending at the tail or dropping
// up to two requests wait in the command queue; busy is high while it is full
// reset is synchronous, active low; the table contents are not cleared
// results cannot be stalled: at most one result leaves per cycle
`include "periodic_task_timer_table_macros.svh"

module periodic_task_timer_table #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_task_id,
    input  logic [7:0]  i_handler_tag,
    input  logic [31:0] i_due_time,
    input  logic [31:0] i_period,
    input  logic [31:0] i_now_time,
    output logic        o_res_valid,
    output logic [1:0]  o_result_kind,
    output logic        o_status,
    output logic [31:0] o_fired_id,
    output logic [7:0]  o_fired_tag,
    output logic [3:0]  o_fire_count,
    output logic        o_last
);
    import ptt_pkg::*;

    t_cmd_q cmd_q;
    logic   pop;
    logic   res_fired;
    logic   res_status;
    logic   status_clean;

    ptt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_req_type    (i_req_type),
        .i_task_id     (i_task_id),
        .i_handler_tag (i_handler_tag),
        .i_due_time    (i_due_time),
        .i_period      (i_period),
        .i_now_time    (i_now_time),
        .o_q           (cmd_q),
        .i_pop         (pop)
    );

    ptt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (cmd_q),
        .o_pop         (pop),
        .o_res_valid   (o_res_valid),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_fired_id    (o_fired_id),
        .o_fired_tag   (o_fired_tag),
        .o_fire_count  (o_fire_count),
        .o_last        (o_last)
    );

    assign res_fired    = o_res_valid && (o_result_kind == RK_FIRED);
    assign res_status   = o_res_valid && (o_result_kind == RK_STATUS);
    assign status_clean = o_last && (o_fired_id == '0) && (o_fire_count == '0);

    // an accepted request is waiting in the queue right after its transfer
    `PTT_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, cmd_q.valid, "request lost")
    // a fired result never closes a request
    `PTT_ASSERT_NOW(a_fired_not_last, i_clk, i_rst_n, res_fired, !o_last, "fired result marked last")
    // a status result is last and carries no task
    `PTT_ASSERT_NOW(a_status_clean, i_clk, i_rst_n, res_status, status_clean, "bad status result")

endmodule

[rtl/ptt_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ptt_front.sv]
// front end: request handshake, decode into a command and a two-entry command queue
// depends on ptt_pkg
module ptt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  logic [1:0]      i_req_type,
    input  logic [31:0]     i_task_id,
    input  logic [7:0]      i_handler_tag,
    input  logic [31:0]     i_due_time,
    input  logic [31:0]     i_period,
    input  logic [31:0]     i_now_time,
    output ptt_pkg::t_cmd_q o_q,
    input  logic            i_pop
);
    import ptt_pkg::*;

    t_cmd       cmd_in;
    logic       push;
    t_cmd       r_q [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_comb begin
        cmd_in.id     = i_task_id;
        cmd_in.tag    = i_handler_tag;
        cmd_in.period = i_period;
        cmd_in.tm     = i_due_time;
        case (t_op'(i_req_type))
            OP_SCHED:  cmd_in.op = OP_SCHED;
            OP_REMOVE: cmd_in.op = OP_REMOVE;
            OP_CHANGE: cmd_in.op = OP_CHANGE;
            OP_RUN: begin
                cmd_in.op = OP_RUN;
                cmd_in.tm = i_now_time;
            end
            default: cmd_in.op = OP_SCHED;
        endcase
    end

    assign o_busy = (r_cnt == 2'(QDEPTH));
    assign push   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.cmd   = r_q[r_rp];

endmodule

[rtl/ptt_back.sv]
// back end: executes queued commands against the ring table and drives the result registers
// depends on ptt_pkg and ptt_ram
module ptt_back #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptt_pkg::t_cmd_q i_q,
    output logic            o_pop,
    output logic            o_res_valid,
    output logic [1:0]      o_result_kind,
    output logic            o_status,
    output logic [31:0]     o_fired_id,
    output logic [7:0]      o_fired_tag,
    output logic [3:0]      o_fire_count,
    output logic            o_last
);
    import ptt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(t_entry);

    t_bk_state   r_state, n_state;
    t_cmd        r_cmd;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic          r_rd_vld;
    logic [3:0]    r_fired, n_fired;

    logic          we, re, full;
    t_entry        wdata, rd_entry;
    logic [EW-1:0] rdata;

    logic          r_res_valid, n_res_valid;
    logic [1:0]    r_kind, n_kind;
    logic          r_status, n_status;
    logic [31:0]   r_fid, n_fid;
    logic [7:0]    r_ftag, n_ftag;
    logic [3:0]    r_fcnt, n_fcnt;
    logic          r_last, n_last;

    ptt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign rd_entry = t_entry'(rdata);
    assign full     = (r_count >= CW'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q.valid) begin
                    n_state = (i_q.cmd.op == OP_SCHED) ? BK_SCHED : BK_SWEEP;
                end
            end
            BK_SCHED:  n_state = BK_IDLE;
            BK_SWEEP: begin
                if (r_left == '0) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_pop       = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        wdata       = rd_entry;
        n_left      = r_left;
        n_fired     = r_fired;
        n_res_valid = 1'b0;
        n_kind      = RK_STATUS;
        n_status    = 1'b0;
        n_fid       = '0;
        n_ftag      = '0;
        n_fcnt      = '0;
        n_last      = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop   = i_q.valid;
                n_left  = r_count;
                n_fired = '0;
            end
            BK_SCHED: begin
                we           = !full;
                wdata.id     = r_cmd.id;
                wdata.tag    = r_cmd.tag;
                wdata.due    = r_cmd.tm;
                wdata.period = r_cmd.period;
                n_res_valid  = 1'b1;
                n_status     = full;
                n_last       = 1'b1;
            end
            BK_SWEEP: begin
                re = (r_left != '0);
                if (re) begin
                    n_left = r_left - 1'b1;
                end
                // entry read last cycle is re-appended at the tail, or dropped
                if (r_rd_vld) begin
                    case (r_cmd.op)
                        OP_REMOVE: we = (rd_entry.id != r_cmd.id);
                        OP_CHANGE: begin
                            we = 1'b1;
                            if (rd_entry.id == r_cmd.id) begin
                                wdata.due    = r_cmd.tm;
                                wdata.period = r_cmd.period;
                            end
                        end
                        OP_RUN: begin
                            if (rd_entry.due <= r_cmd.tm) begin
                                we        = (rd_entry.period != '0);
                                wdata.due = r_cmd.tm + rd_entry.period;
                                if (r_fired != FIRE_SAT) begin
                                    n_fired     = r_fired + 1'b1;
                                    n_res_valid = 1'b1;
                                    n_kind      = RK_FIRED;
                                    n_fid       = rd_entry.id;
                                    n_ftag      = rd_entry.tag;
                                end
                            end else begin
                                we = 1'b1;
                            end
                        end
                        default: we = 1'b0;
                    endcase
                end
            end
            BK_FINISH: begin
                n_res_valid = 1'b1;
                n_last      = 1'b1;
                if (r_cmd.op == OP_RUN) begin
                    n_kind = RK_DONE;
                    n_fcnt = r_fired;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_head  = re ? ((r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1) : r_head;
        n_tail  = we ? ((r_tail == IW'(DEPTH - 1)) ? '0 : r_tail + 1'b1) : r_tail;
        n_count = r_count + CW'(we) - CW'(re);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_fired     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_left      <= n_left;
            r_rd_vld    <= re;
            r_fired     <= n_fired;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q.cmd;
        end
        r_kind   <= n_kind;
        r_status <= n_status;
        r_fid    <= n_fid;
        r_ftag   <= n_ftag;
        r_fcnt   <= n_fcnt;
        r_last   <= n_last;
    end

    assign o_res_valid   = r_res_valid;
    assign o_result_kind = r_kind;
    assign o_status      = r_status;
    assign o_fired_id    = r_fid;
    assign o_fired_tag   = r_ftag;
    assign o_fire_count  = r_fcnt;
    assign o_last        = r_last;

endmodule

[tb/periodic_task_timer_table_checker.sv]
// result checker for the periodic task timer table: predicts the results of every accepted
// request from its own copy of the task table and compares them with the result port
// depends on ptt_pkg
module periodic_task_timer_table_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_task_id,
    input  logic [7:0]  i_handler_tag,
    input  logic [31:0] i_due_time,
    input  logic [31:0] i_period,
    input  logic [31:0] i_now_time,
    input  logic        i_res_valid,
    input  logic [1:0]  i_result_kind,
    input  logic        i_status,
    input  logic [31:0] i_fired_id,
    input  logic [7:0]  i_fired_tag,
    input  logic [3:0]  i_fire_count,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import ptt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [31:0] id;
        logic [7:0]  tag;
        logic [3:0]  count;
        logic        last;
    } t_outcome;

    t_entry   task_table[$];
    t_outcome expected_q[$];
    t_outcome want;
    int       fail_count = 0;

    function automatic t_outcome outcome(logic [1:0] kind, logic status, logic [31:0] id,
                                         logic [7:0] tag, logic [3:0] count, logic last);
        t_outcome o;
        o.kind   = kind;
        o.status = status;
        o.id     = id;
        o.tag    = tag;
        o.count  = count;
        o.last   = last;
        return o;
    endfunction

    task automatic apply_request(t_op op, logic [31:0] id, logic [7:0] tag, logic [31:0] due,
                                 logic [31:0] per, logic [31:0] now);
        t_entry     e;
        int         n;
        int         shown;
        logic [3:0] fired;
        n     = task_table.size();
        shown = 0;
        fired = '0;
        case (op)
            OP_SCHED: begin
                if (n >= DEPTH - 1) begin
                    expected_q.push_back(outcome(RK_STATUS, 1'b1, '0, '0, '0, 1'b1));
                end else begin
                    e.id     = id;
                    e.tag    = tag;
                    e.due    = due;
                    e.period = per;
                    task_table.push_back(e);
                    expected_q.push_back(outcome(RK_STATUS, 1'b0, '0, '0, '0, 1'b1));
                end
            end
            OP_REMOVE, OP_CHANGE: begin
                // one sweep over the ring, re-appending what survives
                for (int i = 0; i < n; i++) begin
                    e = task_table.pop_front();
                    if (e.id == id && op == OP_CHANGE) begin
                        e.due    = due;
                        e.period = per;
                    end
                    if (e.id != id || op == OP_CHANGE)
                        task_table.push_back(e);
                end
                expected_q.push_back(outcome(RK_STATUS, 1'b0, '0, '0, '0, 1'b1));
            end
            OP_RUN: begin
                for (int i = 0; i < n; i++) begin
                    e = task_table.pop_front();
                    if (e.due <= now) begin
                        if (shown < MAX_RESULTS - 1) begin
                            expected_q.push_back(outcome(RK_FIRED, 1'b0, e.id, e.tag, '0, 1'b0));
                            shown++;
                        end
                        if (fired < FIRE_SAT)
                            fired++;
                        // periodic tasks come back at now + period, one-shots are gone
                        if (e.period != 0) begin
                            e.due = now + e.period;
                            task_table.push_back(e);
                        end
                    end else begin
                        task_table.push_back(e);
                    end
                end
                expected_q.push_back(outcome(RK_DONE, 1'b0, '0, '0, fired, 1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid !== 1'b0) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0h id %0h",
                             $time, i_result_kind, i_fired_id);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_result_kind !== want.kind)
                        report_field("result_kind", 32'(want.kind), 32'(i_result_kind));
                    if (i_status !== want.status)
                        report_field("status", 32'(want.status), 32'(i_status));
                    if (i_fired_id !== want.id)
                        report_field("fired_id", want.id, i_fired_id);
                    if (i_fired_tag !== want.tag)
                        report_field("fired_tag", 32'(want.tag), 32'(i_fired_tag));
                    if (i_fire_count !== want.count)
                        report_field("fire_count", 32'(want.count), 32'(i_fire_count));
                    if (i_last !== want.last)
                        report_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                apply_request(t_op'(i_req_type), i_task_id, i_handler_tag, i_due_time,
                              i_period, i_now_time);
        end
        o_pending    = expected_q.size();
        o_fail_count = fail_count;
    end

endmodule

[tb/periodic_task_timer_table_tb.sv]
// testbench top of the periodic task timer table: clock, reset, request stimulus and verdict
// depends on ptt_pkg, periodic_task_timer_table and periodic_task_timer_table_checker
module periodic_task_timer_table_tb;
    import ptt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 45;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_task_id = '0;
    logic [7:0]  i_handler_tag = '0;
    logic [31:0] i_due_time = '0;
    logic [31:0] i_period = '0;
    logic [31:0] i_now_time = '0;
    logic        o_res_valid;
    logic [1:0]  o_result_kind;
    logic        o_status;
    logic [31:0] o_fired_id;
    logic [7:0]  o_fired_tag;
    logic [3:0]  o_fire_count;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          sender_idle_pct = 0;
    int          quiet_cycles = 0;
    bit          timed_out = 1'b0;
    logic [31:0] now_ms = '0;
    logic [31:0] id_pool[6];
    int          idle_by_phase[3] = '{30, 70, 0};

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    periodic_task_timer_table #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_task_id(i_task_id),
        .i_handler_tag(i_handler_tag),
        .i_due_time(i_due_time),
        .i_period(i_period),
        .i_now_time(i_now_time),
        .o_res_valid(o_res_valid),
        .o_result_kind(o_result_kind),
        .o_status(o_status),
        .o_fired_id(o_fired_id),
        .o_fired_tag(o_fired_tag),
        .o_fire_count(o_fire_count),
        .o_last(o_last)
    );

    periodic_task_timer_table_checker #(
        .DEPTH(DEPTH)
    ) u_table_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_req_type(i_req_type),
        .i_task_id(i_task_id),
        .i_handler_tag(i_handler_tag),
        .i_due_time(i_due_time),
        .i_period(i_period),
        .i_now_time(i_now_time),
        .i_res_valid(o_res_valid),
        .i_result_kind(o_result_kind),
        .i_status(o_status),
        .i_fired_id(o_fired_id),
        .i_fired_tag(o_fired_tag),
        .i_fire_count(o_fire_count),
        .i_last(o_last),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // one request transfer; start stays high between back-to-back requests
    task automatic issue(t_op op, logic [31:0] id, logic [7:0] tag, logic [31:0] due,
                         logic [31:0] per, logic [31:0] now);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_req_type    = op;
        i_task_id     = id;
        i_handler_tag = tag;
        i_due_time    = due;
        i_period      = per;
        i_now_time    = now;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // mostly ids from a small pool and times near the running clock, some raw noise
    task automatic random_request();
        int          pick;
        t_op         op;
        logic [31:0] id;
        logic [7:0]  tag;
        logic [31:0] due;
        logic [31:0] per;
        logic [31:0] now;
        pick = $urandom_range(99);
        op   = (pick < 45) ? OP_SCHED : (pick < 57) ? OP_REMOVE :
               (pick < 67) ? OP_CHANGE : OP_RUN;
        id   = ($urandom_range(15) == 0) ? $urandom : id_pool[$urandom_range(5)];
        tag  = 8'($urandom_range(255));
        due  = now_ms + $urandom_range(60);
        per  = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(1, 50));
        now  = $urandom;
        if (op == OP_RUN) begin
            now_ms = now_ms + $urandom_range(40);
            now    = now_ms;
        end
        if ($urandom_range(11) == 0) begin
            due = $urandom;
            per = $urandom;
            now = $urandom;
        end
        issue(op, id, tag, due, per, now);
    endtask

    initial begin
        foreach (id_pool[k])
            id_pool[k] = $urandom;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        fork
            begin
                sender_idle_pct = idle_by_phase[0];
                // empty table: run and unmatched remove / change
                issue(OP_RUN, $urandom, 8'($urandom), $urandom, $urandom, 32'd0);
                issue(OP_REMOVE, 32'd5, 8'($urandom), $urandom, $urandom, $urandom);
                issue(OP_CHANGE, 32'd5, 8'($urandom), $urandom, $urandom, $urandom);
                issue(OP_SCHED, 32'd0, 8'h00, 32'd0, 32'd0, $urandom);
                issue(OP_SCHED, '1, 8'hff, '1, '1, $urandom);
                issue(OP_SCHED, 32'd1, 8'h5a, 32'd10, 32'd0, $urandom);
                issue(OP_SCHED, 32'd2, 8'ha5, 32'd20, 32'd7, $urandom);
                issue(OP_RUN, $urandom, 8'($urandom), $urandom, $urandom, 32'd15);
                issue(OP_CHANGE, 32'd2, 8'($urandom), 32'd0, 32'hffff_fff0, $urandom);
                // due at the top of the range, reschedule wraps past zero
                issue(OP_RUN, $urandom, 8'($urandom), $urandom, $urandom, '1);
                // fill to capacity with duplicate ids, the last one is refused
                for (int k = 0; k < 14; k++)
                    issue(OP_SCHED, 32'd3, 8'(k), 32'(k), (k % 2) ? 32'(k) : 32'd0, $urandom);
                issue(OP_RUN, $urandom, 8'($urandom), $urandom, $urandom, '1);
                issue(OP_REMOVE, 32'd3, 8'($urandom), $urandom, $urandom, $urandom);
                wait_all_results();
                for (int phase = 0; phase < 3; phase++) begin
                    sender_idle_pct = idle_by_phase[phase];
                    repeat (PHASE_ITEMS) random_request();
                    wait_all_results();
                end
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            begin
                // nothing transferred for too long ends the run
                while (quiet_cycles < QUIET_LIMIT) begin
                    @(posedge i_clk);
                    if ((start && !busy) || o_res_valid === 1'b1)
                        quiet_cycles = 0;
                    else
                        quiet_cycles++;
                end
                timed_out = 1'b1;
            end
        join_any
        disable fork;
        if (!timed_out && fail_count == 0 && pending == 0)
            $display("[periodic_task_timer_table] OK");
        else
            $display("[periodic_task_timer_table] ERROR");
        $finish;
    end

endmodule
